// ===== rtl/pws_pkg.sv =====
// ----------------------------------------------------------------------------
// pws_pkg
// Shared widths, layer codes, azimuth constants and the fixed cumulative
// tables of the phi wiggle table sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package pws_pkg;

   localparam int FRAC_BITS    = 24;
   localparam int TABLE_BINS_D = 50;
   localparam int SRC_BINS     = 50;
   localparam int NUM_TABLES   = 3;

   localparam int PHI_W   = 31;
   localparam int FRAC_W  = 24;
   localparam int BIN_W   = 7;
   localparam int OFS_W   = 23;
   localparam int LAYER_W = 5;
   localparam int ENTRY_W = FRAC_BITS + 1;
   localparam int X_W     = PHI_W + 1;

   localparam logic [LAYER_W-1:0] LAYER_STRIP  = 5'd1;
   localparam logic [LAYER_W-1:0] LAYER_MIDDLE = 5'd2;
   localparam logic [LAYER_W-1:0] LAYER_BACK   = 5'd3;

   localparam logic signed [X_W-1:0] PI_Q     = 32'sd843314857;
   localparam logic signed [X_W-1:0] TWO_PI_Q = 32'sd1686629713;

   // cell width in units of 1e-7 rad
   localparam longint CELL_E7 = 245437;

   typedef struct packed {
      logic                    active;
      logic signed [BIN_W-1:0] bin;
   } bin_sel_type;

   localparam int unsigned DEC_TABLE [0:NUM_TABLES-1][0:SRC_BINS-1] = '{
      '{110626, 242509, 398173, 557610, 736173, 938847, 1151540, 1363900,
        1576440, 1789340, 2001820, 2214730, 2427450, 2640190, 2852640, 3065270,
        3278110, 3491190, 3703870, 3916680, 4129220, 4342080, 4554600, 4767320,
        4980230, 5193100, 5405270, 5617990, 5830790, 6043580, 6256140, 6468640,
        6681120, 6893510, 7106290, 7318940, 7531800, 7744260, 7956950, 8169900,
        8382580, 8595280, 8807830, 9020200, 9225150, 9412760, 9584770, 9750620,
        9889220, 10000000},
      '{127507, 255775, 395137, 542644, 695555, 858206, 1022740, 1196530,
        1378320, 1567770, 1769380, 1977270, 2175760, 2366150, 2566050, 2777660,
        2995000, 3219510, 3446630, 3679030, 3924010, 4174730, 4435140, 4708670,
        4982960, 5257300, 5531140, 5792100, 6043260, 6288220, 6521910, 6748530,
        6972680, 7189830, 7399510, 7598660, 7788770, 7987620, 8195590, 8397890,
        8589230, 8773270, 8948310, 9116930, 9282100, 9439100, 9591560, 9735930,
        9867520, 10000000},
      '{217932, 438502, 670992, 910850, 1165100, 1430380, 1695240, 1962050,
        2229440, 2497030, 2766290, 3035590, 3303400, 3568420, 3835790, 4103850,
        4372720, 4642140, 4911800, 5182020, 5454540, 5726670, 6000370, 6275440,
        6550720, 6826000, 7098240, 7330710, 7547640, 7756720, 7938340, 8109040,
        8282190, 8441190, 8583390, 8712480, 8824850, 8948890, 9079550, 9202890,
        9311360, 9410390, 9498440, 9576410, 9657870, 9739200, 9817060, 9888920,
        9945270, 10000000}
   };

   // cumulative entry in Q0.FRAC_BITS, slots past the given entries never match
   function automatic logic [ENTRY_W-1:0] cdf_entry(input int t, input int i);
      longint unsigned e;
      begin
         e = longint'(1) << FRAC_BITS;
         if (i < SRC_BINS) begin
            e = ((longint'(DEC_TABLE[t][i]) << FRAC_BITS) + 64'd5000000) / 64'd10000000;
         end
         return ENTRY_W'(e);
      end
   endfunction

   // offset for bin k-1 in Q2.28, rounded half away from zero
   function automatic logic signed [OFS_W-1:0] ofs_entry(input int k);
      longint m;
      longint num;
      longint q;
      begin
         m   = 2 * longint'(k) - 49;
         num = m * CELL_E7 * 64'sd268435456;
         if (num >= 0) begin
            q = (num + 64'sd500000000) / 64'sd1000000000;
         end else begin
            q = -((-num + 64'sd500000000) / 64'sd1000000000);
         end
         return OFS_W'(q);
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pws_if.sv =====
// ----------------------------------------------------------------------------
// pws channel interfaces
// Hit request, sampled response and layer register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pws_req_if import pws_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [PHI_W-1:0] phi_in;
   logic [FRAC_W-1:0]       random_fraction;

   modport source (output valid, phi_in, random_fraction, input ready);
   modport sink   (input valid, phi_in, random_fraction, output ready);
endinterface

interface pws_rsp_if import pws_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [PHI_W-1:0] phi_out;
   logic signed [BIN_W-1:0] chosen_bin;
   logic signed [OFS_W-1:0] offset;

   modport source (output valid, phi_out, chosen_bin, offset, input ready);
   modport sink   (input valid, phi_out, chosen_bin, offset, output ready);
endinterface

interface pws_csr_if import pws_pkg::*;;
   logic               valid;
   logic               ready;
   logic [LAYER_W-1:0] layer;

   modport source (output valid, layer, input ready);
   modport sink   (input valid, layer, output ready);
endinterface

`default_nettype wire

// ===== rtl/pws_bin_search.sv =====
// ----------------------------------------------------------------------------
// pws_bin_search
// Parallel compare of the random fraction against the selected layer's
// cumulative table and pick of the highest bin not above it.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_bin_search import pws_pkg::*; #(
   parameter int TABLE_BINS = TABLE_BINS_D
) (
   input  wire logic [LAYER_W-1:0] layer,
   input  wire logic [FRAC_W-1:0]  frac,
   output bin_sel_type             sel
);

   logic [TABLE_BINS-1:0] hit;
   logic                  active;

   assign active = (layer == LAYER_STRIP) || (layer == LAYER_MIDDLE) || (layer == LAYER_BACK);

   for (genvar k = 0; k < TABLE_BINS; k++) begin : g_cmp
      localparam logic [ENTRY_W-1:0] E_STRIP  = cdf_entry(0, k);
      localparam logic [ENTRY_W-1:0] E_MIDDLE = cdf_entry(1, k);
      localparam logic [ENTRY_W-1:0] E_BACK   = cdf_entry(2, k);
      logic [ENTRY_W-1:0] entry;

      always_comb begin
         unique case (layer)
            LAYER_STRIP:  entry = E_STRIP;
            LAYER_MIDDLE: entry = E_MIDDLE;
            LAYER_BACK:   entry = E_BACK;
            default:      entry = E_BACK;
         endcase
      end

      assign hit[k] = ENTRY_W'(frac) >= entry;
   end

   always_comb begin
      sel.active = active;
      sel.bin    = {BIN_W{1'b1}};
      for (int k = 0; k < TABLE_BINS; k++) begin
         if (hit[k]) begin
            sel.bin = BIN_W'(k);
         end
      end
      if (!active) begin
         sel.bin = '0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pws_phi_shift.sv =====
// ----------------------------------------------------------------------------
// pws_phi_shift
// Offset lookup for the chosen bin, subtraction from the azimuth and a
// single wrap into [-pi, pi).
// ----------------------------------------------------------------------------
`default_nettype none

module pws_phi_shift import pws_pkg::*; #(
   parameter int TABLE_BINS = TABLE_BINS_D
) (
   input  wire logic signed [PHI_W-1:0] phi,
   input  wire bin_sel_type             sel,
   output logic signed [PHI_W-1:0]      phi_out,
   output logic signed [OFS_W-1:0]      offset
);

   localparam int IDX_W = $clog2(TABLE_BINS + 1);

   logic signed [OFS_W-1:0] ofs_tab [0:TABLE_BINS];
   logic [BIN_W-1:0]        idx_full;
   logic [IDX_W-1:0]        idx;
   logic signed [X_W-1:0]   x;
   logic signed [X_W-1:0]   x_wrap;

   for (genvar k = 0; k <= TABLE_BINS; k++) begin : g_ofs
      localparam logic signed [OFS_W-1:0] OFS_K = ofs_entry(k);
      assign ofs_tab[k] = OFS_K;
   end

   assign idx_full = sel.bin + BIN_W'(1);
   assign idx      = idx_full[IDX_W-1:0];
   assign offset   = sel.active ? ofs_tab[idx] : '0;
   assign x        = X_W'(phi) - X_W'(offset);

   always_comb begin
      x_wrap = x;
      if (x >= PI_Q) begin
         x_wrap = x - TWO_PI_Q;
      end else if (x < -PI_Q) begin
         x_wrap = x + TWO_PI_Q;
      end
   end

   assign phi_out = x_wrap[PHI_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/phi_wiggle_table_sampler.sv =====
// ----------------------------------------------------------------------------
// phi_wiggle_table_sampler
// Shifts a hit azimuth by a randomly sampled, layer dependent cell offset.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : one beat per hit, phi_in (Q2.28) and random_fraction (Q0.24)
//   rsp_ch  : one beat per hit, phi_out, chosen_bin and offset, in order
//   csr_ch  : writes the sampling layer; always ready, write only when idle
// A hit beat lands in an input register; one pass of table compare, offset
// lookup, subtract and wrap feeds the output register that drives rsp_ch.
// Throughput is one hit per cycle while rsp_ch does not stall, set by the
// single registered pass with all table bins compared at once.
// Reset clears both pipeline valids and sets the layer to 0, which applies
// no offset. When rsp_ch stalls, the output register holds its beat and the
// input register can still take one more hit; req_ch.ready drops only when
// both registers are full and the output is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module phi_wiggle_table_sampler import pws_pkg::*; #(
   parameter int TABLE_BINS = TABLE_BINS_D
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pws_req_if.sink     req_ch,
   pws_rsp_if.source   rsp_ch,
   pws_csr_if.sink     csr_ch
);

   logic [LAYER_W-1:0]      layer_ff;
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [PHI_W-1:0] s1_phi_ff;
   logic [FRAC_W-1:0]       s1_frac_ff;
   logic                    out_valid_ff, out_valid_in;
   logic signed [PHI_W-1:0] out_phi_ff;
   logic signed [BIN_W-1:0] out_bin_ff;
   logic signed [OFS_W-1:0] out_ofs_ff;

   logic                    req_fire;
   logic                    load_out;
   logic                    advance;
   bin_sel_type             sel;
   logic signed [PHI_W-1:0] phi_shift;
   logic signed [OFS_W-1:0] offset;

   assign csr_ch.ready = 1'b1;
   assign load_out     = !out_valid_ff || rsp_ch.ready;
   assign advance      = s1_valid_ff && load_out;
   assign req_ch.ready = !s1_valid_ff || load_out;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !load_out);
   assign out_valid_in = load_out ? s1_valid_ff : 1'b1;

   pws_bin_search #(.TABLE_BINS(TABLE_BINS)) u_search (
      .layer (layer_ff),
      .frac  (s1_frac_ff),
      .sel   (sel)
   );

   pws_phi_shift #(.TABLE_BINS(TABLE_BINS)) u_shift (
      .phi     (s1_phi_ff),
      .sel     (sel),
      .phi_out (phi_shift),
      .offset  (offset)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            layer_ff <= csr_ch.layer;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_phi_ff  <= req_ch.phi_in;
         s1_frac_ff <= req_ch.random_fraction;
      end
      if (advance) begin
         out_phi_ff <= phi_shift;
         out_bin_ff <= sel.bin;
         out_ofs_ff <= offset;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.phi_out    = out_phi_ff;
   assign rsp_ch.chosen_bin = out_bin_ff;
   assign rsp_ch.offset     = out_ofs_ff;

   // layers without a table carry no offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !(layer_ff == LAYER_STRIP || layer_ff == LAYER_MIDDLE ||
                        layer_ff == LAYER_BACK)
      |-> rsp_ch.chosen_bin == '0 && rsp_ch.offset == '0)
      else $error("offset on a layer without table");

   // wrapped azimuth stays in [-pi, pi)
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> X_W'(rsp_ch.phi_out) >= -PI_Q && X_W'(rsp_ch.phi_out) < PI_Q)
      else $error("phi out of wrap range");

   // bin stays in [-1, TABLE_BINS-1]
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> int'(rsp_ch.chosen_bin) >= -1 &&
                       int'(rsp_ch.chosen_bin) < TABLE_BINS)
      else $error("bin out of table range");

   // a loaded input beat reaches the output register on the next edge
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result lost between stages");

endmodule

`default_nettype wire
